// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the avoid node table.
// Relies on the including module having clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset
`define AST_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, quiet during reset
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/avt_pkg.sv =====
// Package for the avoid node table: constants, operation codes and entry type.
// No dependencies.
package avt_pkg;

  localparam int unsigned DEFAULT_DEPTH   = 16;
  localparam logic [31:0] EPOCH_CEILING   = 32'd1000000;
  localparam logic [15:0] USES_MAX        = 16'hFFFF;
  localparam logic [15:0] CHECK_LIMIT_RST = 16'd100;

  // Operation codes on in_func
  localparam logic [1:0] FUNC_LOOKUP  = 2'd0;
  localparam logic [1:0] FUNC_JOIN    = 2'd1;
  localparam logic [1:0] FUNC_REROUTE = 2'd2;

  typedef struct packed {
    logic [31:0] map_id;
    logic [31:0] block_id;
    logic [31:0] node_id;
    logic [31:0] epoch;
    logic [15:0] uses;
  } entry_t;

endpackage

// ===== rtl/avoid_node_table.sv =====
// Avoid node table top level: keyed use-count table with epoch-based replacement.
// Depends on avt_pkg and assert_macros.svh.
// One item at a time. Lookups within the check limit and joins scan every table
// slot through a single memory read port, one slot per cycle, in ST_SCAN, then
// pass ST_LAST. A lookup's result is loaded in ST_FIN. Reroutes, unused codes and
// lookups past the check limit go straight to ST_FIN. A join writes the chosen
// slot in ST_WRITE, between ST_LAST and ST_FIN, and loads its result in ST_FIN.
// in_stall stays high from the transfer of an item until its result is loaded
// into the output register. The table needs no clearing pass after reset: a
// per-slot valid bit makes an unwritten slot read as all zero.
`include "assert_macros.svh"

module avoid_node_table #(
  parameter int unsigned TABLE_DEPTH = avt_pkg::DEFAULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_map_id,
  input  logic [31:0] in_block_id,
  input  logic [31:0] in_node_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_hit_count
);
  import avt_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_LAST  = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  // Table storage and per-slot valid bits
  entry_t           mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] slot_valid_r;

  logic [2:0]       state_r, state_nxt;
  logic [15:0]      check_limit_r;
  logic [16:0]      lookup_cnt_r;
  logic [31:0]      epoch_r;

  logic [1:0]       func_r;
  logic [31:0]      map_r, block_r, node_r;

  logic [IDX_W-1:0] addr_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  entry_t           rd_data_r;
  logic             rd_slot_valid_r;

  logic             found_r;
  logic [IDX_W-1:0] found_idx_r;
  logic [15:0]      found_uses_r;
  logic [31:0]      best_epoch_r;
  logic [IDX_W-1:0] best_idx_r;

  logic             out_valid_r;
  logic [15:0]      out_hit_r;

  logic             in_xfer;
  logic             out_free;
  logic             lookup_ok;
  entry_t           cur;
  logic             cur_match;
  entry_t           wr_entry;
  logic [IDX_W-1:0] wr_idx;

  assign in_stall      = (state_r != ST_IDLE);
  assign in_xfer       = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_hit_count = out_hit_r;
  assign out_free      = !out_valid_r || !out_stall;
  assign lookup_ok     = (lookup_cnt_r <= {1'b0, check_limit_r});

  // Entry under compare; an unwritten slot reads as zero
  assign cur       = rd_slot_valid_r ? rd_data_r : '0;
  assign cur_match = (cur.uses != 16'd0) && (cur.map_id == map_r) &&
                     (cur.block_id == block_r) && (cur.node_id == node_r);

  // Entry written at the end of a join: bump a match or replace the chosen slot
  always_comb begin
    wr_entry.map_id   = map_r;
    wr_entry.block_id = block_r;
    wr_entry.node_id  = node_r;
    wr_entry.epoch    = epoch_r;
    if (found_r) begin
      wr_entry.uses = (found_uses_r == USES_MAX) ? USES_MAX : found_uses_r + 16'd1;
      wr_idx        = found_idx_r;
    end else begin
      wr_entry.uses = 16'd1;
      wr_idx        = best_idx_r;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if ((in_func == FUNC_JOIN) || ((in_func == FUNC_LOOKUP) && lookup_ok)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        if (addr_r == LAST_IDX) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = (func_r == FUNC_JOIN) ? ST_WRITE : ST_FIN;
      end
      ST_WRITE: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state, counters and config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      check_limit_r <= CHECK_LIMIT_RST;
      lookup_cnt_r  <= '0;
      epoch_r       <= '0;
      slot_valid_r  <= '0;
      rd_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == ST_SCAN);
      if (cfg_we) begin
        check_limit_r <= cfg_wdata;
      end
      // Count lookups within limit; reroute opens a new epoch
      if (in_xfer && (in_func == FUNC_LOOKUP) && lookup_ok) begin
        lookup_cnt_r <= lookup_cnt_r + 17'd1;
      end
      if (in_xfer && (in_func == FUNC_REROUTE)) begin
        lookup_cnt_r <= '0;
        epoch_r      <= epoch_r + 32'd1;
      end
      if (state_r == ST_WRITE) begin
        slot_valid_r[wr_idx] <= 1'b1;
      end
      // Drop the result on transfer, load a new one at the end of an item
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item registers, scan address and running search results
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r       <= in_func;
      map_r        <= in_map_id;
      block_r      <= in_block_id;
      node_r       <= in_node_id;
      addr_r       <= '0;
      found_r      <= 1'b0;
      found_idx_r  <= '0;
      found_uses_r <= '0;
      best_epoch_r <= EPOCH_CEILING;
      best_idx_r   <= '0;
    end else begin
      if (state_r == ST_SCAN && addr_r != LAST_IDX) begin
        addr_r <= addr_r + IDX_W'(1);
      end
      if (rd_vld_r) begin
        // Keep the first live match
        if (cur_match && !found_r) begin
          found_r      <= 1'b1;
          found_idx_r  <= rd_idx_r;
          found_uses_r <= cur.uses;
        end
        // Keep the first slot with the strictly smallest epoch
        if (best_epoch_r > cur.epoch) begin
          best_epoch_r <= cur.epoch;
          best_idx_r   <= rd_idx_r;
        end
      end
    end
    if (state_r == ST_FIN && out_free) begin
      out_hit_r <= ((func_r == FUNC_LOOKUP) && found_r) ? found_uses_r : 16'd0;
    end
  end

  // Table memory: one registered read port, one write port
  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN) begin
      rd_data_r       <= mem[addr_r];
      rd_slot_valid_r <= slot_valid_r[addr_r];
      rd_idx_r        <= addr_r;
    end
    if (state_r == ST_WRITE) begin
      mem[wr_idx] <= wr_entry;
    end
  end

  // Checks
  `AST_NEXT(a_xfer_busy, in_xfer, state_r != ST_IDLE)
  `AST_IMPL(a_out_from_fin, $rose(out_valid_r), $past(state_r == ST_FIN))
  `AST_IMPL(a_write_join, state_r == ST_WRITE, func_r == FUNC_JOIN)

endmodule

// ===== tb/sv/tb_avoid_node_table.sv =====
// Testbench for the avoid node table: directed and random lookup, join and
// reroute traffic, with each hit count predicted by a local table model.
// Depends on avt_pkg and the avoid_node_table RTL.
`timescale 1ns / 100ps

module tb_avoid_node_table;
  import avt_pkg::*;

  localparam int unsigned DEPTH      = DEFAULT_DEPTH;
  localparam logic [1:0]  FUNC_SPARE = 2'd3;
  localparam int unsigned KEY_POOL   = 24;
  localparam int unsigned SETTLE     = DEPTH + 8;
  localparam int unsigned MAX_PRINTS = 50;
  localparam int unsigned BUMP_RUN   = 40;
  localparam logic [15:0] LIMIT_MAX  = 16'hFFFF;
  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_func;
  logic [31:0] in_map_id;
  logic [31:0] in_block_id;
  logic [31:0] in_node_id;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_hit_count;

  // Local copy of the table, counters and check limit
  entry_t      slot_q [DEPTH];
  logic [16:0] lookups_in_epoch;
  logic [31:0] epoch_now;
  logic [15:0] limit_now;
  logic [15:0] hit_fifo [$];

  // Keys that recur, so that joins and lookups find each other
  logic [31:0] pool_map   [KEY_POOL];
  logic [31:0] pool_block [KEY_POOL];
  logic [31:0] pool_node  [KEY_POOL];

  int unsigned errors;
  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned hold_request;

  avoid_node_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_map_id    (in_map_id),
    .in_block_id  (in_block_id),
    .in_node_id   (in_node_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_hit_count(out_hit_count)
  );

  always #10 clk = ~clk;

  // Count a mismatch; cap the printout so a broken build stays readable
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // Index of the live slot holding the key, or -1
  function automatic int find_live(input logic [31:0] m, input logic [31:0] b,
                                   input logic [31:0] n);
    int i;
    for (i = 0; i < DEPTH; i++)
      if (slot_q[i].uses != '0 && slot_q[i].map_id == m &&
          slot_q[i].block_id == b && slot_q[i].node_id == n)
        return i;
    return -1;
  endfunction

  // Apply one item to the local table and return the hit count it yields
  function automatic logic [15:0] apply_item(input logic [1:0] f, input logic [31:0] m,
                                             input logic [31:0] b, input logic [31:0] n);
    int          k;
    int          i;
    int          victim;
    logic [31:0] oldest;
    logic [15:0] hit;
    hit = '0;
    k = find_live(m, b, n);
    case (f)
      FUNC_LOOKUP: begin
        // past the limit: answer zero and stop counting
        if (lookups_in_epoch <= {1'b0, limit_now}) begin
          lookups_in_epoch = lookups_in_epoch + 17'd1;
          if (k >= 0)
            hit = slot_q[k].uses;
        end
      end
      FUNC_JOIN: begin
        if (k >= 0) begin
          if (slot_q[k].uses != USES_MAX)
            slot_q[k].uses = slot_q[k].uses + 16'd1;
          slot_q[k].epoch = epoch_now;
        end else begin
          // first slot with the strictly smallest epoch under the ceiling
          oldest = EPOCH_CEILING;
          victim = 0;
          for (i = 0; i < DEPTH; i++)
            if (slot_q[i].epoch < oldest) begin
              oldest = slot_q[i].epoch;
              victim = i;
            end
          slot_q[victim] = '{map_id: m, block_id: b, node_id: n,
                             epoch: epoch_now, uses: 16'd1};
        end
      end
      FUNC_REROUTE: begin
        lookups_in_epoch = '0;
        epoch_now = epoch_now + 32'd1;
      end
      default: ;
    endcase
    return hit;
  endfunction

  // Offer one item, hold it until the transfer, then queue its hit count
  task automatic send_item(input logic [1:0] f, input logic [31:0] m,
                           input logic [31:0] b, input logic [31:0] n);
    int unsigned gap;
    gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_func     <= f;
    in_map_id   <= m;
    in_block_id <= b;
    in_node_id  <= n;
    do @(posedge clk); while (in_stall);
    hit_fifo.push_back(apply_item(f, m, b, n));
  endtask

  // Drop valid, wait for every outstanding hit count, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (hit_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    limit_now = value;
  endtask

  // Mostly pool keys, a tenth fully random ones
  task automatic send_random_item(input int unsigned reroute_pct);
    int unsigned roll;
    int unsigned k;
    logic [1:0]  f;
    roll = $urandom_range(0, 99);
    if (roll < reroute_pct)
      f = FUNC_REROUTE;
    else if (roll < reroute_pct + 4)
      f = FUNC_SPARE;
    else
      f = $urandom_range(0, 1) ? FUNC_JOIN : FUNC_LOOKUP;
    if ($urandom_range(0, 9) == 0) begin
      send_item(f, $urandom, $urandom, $urandom);
    end else begin
      k = $urandom_range(0, KEY_POOL - 1);
      send_item(f, pool_map[k], pool_block[k], pool_node[k]);
    end
  endtask

  task automatic test_empty_table();
    send_item(FUNC_LOOKUP, '0, '0, '0);
    send_item(FUNC_LOOKUP, ALL_ONES, ALL_ONES, ALL_ONES);
    send_item(FUNC_SPARE, ALL_ONES, ALL_ONES, ALL_ONES);
  endtask

  task automatic test_join_and_bump();
    send_item(FUNC_JOIN, '0, '0, '0);
    send_item(FUNC_JOIN, ALL_ONES, ALL_ONES, ALL_ONES);
    send_item(FUNC_JOIN, ALL_ONES, ALL_ONES, ALL_ONES);
    send_item(FUNC_LOOKUP, '0, '0, '0);
    send_item(FUNC_LOOKUP, ALL_ONES, ALL_ONES, ALL_ONES);
    // keys that differ in one part only must miss
    send_item(FUNC_LOOKUP, ALL_ONES, ALL_ONES, ALL_ONES - 32'd1);
    send_item(FUNC_LOOKUP, '0, ALL_ONES, ALL_ONES);
  endtask

  task automatic test_reroute_and_spare();
    send_item(FUNC_REROUTE, ALL_ONES, ALL_ONES, ALL_ONES);
    send_item(FUNC_JOIN, '0, '0, '0);
    send_item(FUNC_SPARE, '0, '0, '0);
    send_item(FUNC_LOOKUP, '0, '0, '0);
  endtask

  task automatic test_check_limit();
    wait_idle();
    write_limit('0);
    send_item(FUNC_LOOKUP, ALL_ONES, ALL_ONES, ALL_ONES);
    send_item(FUNC_LOOKUP, ALL_ONES, ALL_ONES, ALL_ONES);
    send_item(FUNC_REROUTE, '0, '0, '0);
    send_item(FUNC_LOOKUP, ALL_ONES, ALL_ONES, ALL_ONES);
    wait_idle();
    write_limit(LIMIT_MAX);
    send_item(FUNC_LOOKUP, '0, '0, '0);
  endtask

  // Bump one key many times, back to back
  task automatic test_repeated_bump();
    logic [31:0] m;
    logic [31:0] b;
    logic [31:0] n;
    m = $urandom;
    b = $urandom;
    n = $urandom;
    wait_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (BUMP_RUN) send_item(FUNC_JOIN, m, b, n);
    send_item(FUNC_REROUTE, m, b, n);
    send_item(FUNC_LOOKUP, m, b, n);
    wait_idle();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Long receiver hold-off while the sender keeps offering, then a full drain
  task automatic test_hold_off();
    wait_idle();
    hold_request = 200;
    repeat (10) send_random_item(5);
    wait_idle();
  endtask

  task automatic run_random(input logic [15:0] limit, input int unsigned count,
                            input int unsigned reroute_pct);
    wait_idle();
    write_limit(limit);
    repeat (count) send_random_item(reroute_pct);
  endtask

  task automatic test_random_phases();
    run_random(CHECK_LIMIT_RST, 400, 8);
    run_random('0, 250, 10);
    run_random(16'd5, 300, 3);
    run_random(16'd20, 300, 1);
    run_random(LIMIT_MAX, 300, 5);
    // quiet finish: no idling on either side
    wait_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random(16'd1, 250, 6);
  endtask

  // Receiver stall: long hold-off first, then random bursts
  initial begin : rx_stall_gen
    int unsigned burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        out_stall <= 1'b1;
        hold_request--;
      end else if (burst != 0) begin
        out_stall <= 1'b1;
        burst--;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(0, 7);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare every output transfer with the oldest predicted hit count
  always @(posedge clk) begin : hit_check
    logic [15:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (hit_fifo.size() == 0) begin
        report_mismatch("transfer with nothing pending", out_hit_count, '0);
      end else begin
        want = hit_fifo.pop_front();
        if (out_hit_count !== want)
          report_mismatch("hit_count", out_hit_count, want);
      end
    end
  end

  initial begin
    #150_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : main_flow
    int i;
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_func      = FUNC_LOOKUP;
    in_map_id    = '0;
    in_block_id  = '0;
    in_node_id   = '0;
    errors       = 0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    hold_request = 0;

    // predictor starts from the reset state
    for (i = 0; i < DEPTH; i++)
      slot_q[i] = '0;
    lookups_in_epoch = '0;
    epoch_now        = '0;
    limit_now        = CHECK_LIMIT_RST;

    // pool: the two extreme keys, then groups sharing key parts
    pool_map[0]   = '0;
    pool_block[0] = '0;
    pool_node[0]  = '0;
    pool_map[1]   = ALL_ONES;
    pool_block[1] = ALL_ONES;
    pool_node[1]  = ALL_ONES;
    for (i = 2; i < KEY_POOL; i++) begin
      pool_map[i]   = (i % 4 != 0) ? pool_map[i - 1] : $urandom;
      pool_block[i] = (i % 4 == 3) ? pool_block[i - 1] : $urandom;
      pool_node[i]  = (i % 4 == 3) ? pool_node[i - 1] ^ (32'd1 << $urandom_range(0, 31))
                                   : $urandom;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_join_and_bump();
    test_reroute_and_spare();
    test_check_limit();
    test_repeated_bump();
    test_hold_off();
    test_random_phases();

    wait_idle();
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/avt_pkg.sv
rtl/avoid_node_table.sv
tb/sv/tb_avoid_node_table.sv
